/* rtl/scd_pkg.sv */
// Shared types, constants and the argument-length table of the sequence command decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package scd_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_SEQUENCE_BASE    = 2'd0;
  localparam logic [1:0] CFG_TRACK_START      = 2'd1;
  localparam logic [1:0] CFG_NOTEWAIT_DEFAULT = 2'd2;

  // Argument kinds: 0..5 fixed argument bytes, plus two special codes
  localparam logic [2:0] KIND_VAR = 3'd6;
  localparam logic [2:0] KIND_BAD = 3'd7;

  // Command codes with special handling
  localparam logic [7:0] CODE_NOTE_LIMIT = 8'h80;
  localparam logic [7:0] CODE_END        = 8'hFF;

  // Finished-command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_VEL,
    PH_VARLEN,
    PH_FIXED,
    PH_STOP
  } phase_t;

  // One finished command handed from front to queue
  typedef struct packed {
    logic       valid;
    logic [7:0] code;
  } cmd_push_t;

  // Queue status seen by the back and the top level
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // Argument bytes that follow a command code
  function automatic logic [2:0] arg_kind(input logic [7:0] c);
    logic [2:0] k;
    k = KIND_BAD;
    if (c < CODE_NOTE_LIMIT) begin
      k = 3'd1;
    end else begin
      case (c) inside
        8'h80, 8'h81:                   k = KIND_VAR;
        8'h93:                          k = 3'd4;
        8'h94, 8'h95:                   k = 3'd3;
        8'hA0:                          k = 3'd5;
        8'hA1:                          k = 3'd2;
        8'hA2, 8'hFC, 8'hFD:            k = 3'd0;
        [8'hB0:8'hB6], [8'hB8:8'hBD]:   k = 3'd3;
        [8'hC0:8'hD6]:                  k = 3'd1;
        8'hE0, 8'hE1, 8'hE3, 8'hFE:     k = 3'd2;
        default:                        k = KIND_BAD;
      endcase
    end
    return k;
  endfunction

endpackage

`default_nettype wire

/* rtl/sequence_command_decoder.sv */
// Sequence command decoder: a user takes one sequence byte per cycle at in_ready and gets one
// transaction per finished command carrying its code. A byte is taken every cycle while the
// four-entry command queue has room; at the earliest, out_valid rises at the clock edge right
// after the one that takes a command's last byte. After the end-of-track code or an unknown
// code, bytes are still taken but give no result until reset. Configuration writes are taken
// every cycle; sequence_base, track_start and notewait_default are held here but feed nothing
// that reaches the code stream.
// Depends on scd_pkg, scd_front, scd_queue and scd_back.
`default_nettype none

module sequence_command_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_command_code
);
  import scd_pkg::*;

  cmd_push_t     push;
  queue_status_t q_status;
  logic          stopped;
  logic          byte_take;
  logic          pop;
  logic [7:0]    head_code;

  logic [31:0] sequence_base_r;
  logic [31:0] track_start_r;
  logic        notewait_default_r;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sequence_base_r    <= '0;
      track_start_r      <= '0;
      notewait_default_r <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SEQUENCE_BASE:    sequence_base_r    <= cfg_data;
        CFG_TRACK_START:      track_start_r      <= cfg_data;
        CFG_NOTEWAIT_DEFAULT: notewait_default_r <= cfg_data[0];
        default:              ;
      endcase
    end
  end

  // Take a byte whenever the queue has room
  assign in_ready  = !q_status.full;
  assign byte_take = in_valid && in_ready;

  scd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_take (byte_take),
    .data_byte (in_data_byte),
    .push      (push),
    .stopped   (stopped)
  );

  scd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (pop),
    .head_code (head_code),
    .status    (q_status)
  );

  scd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_status         (q_status),
    .head_code        (head_code),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_command_code (out_command_code)
  );

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> !q_status.full)
    else $error("command pushed into full queue");

  a_no_push_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    stopped |-> !push.valid)
    else $error("command finished after track stop");

  a_out_from_queue: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(pop))
    else $error("result presented without queue pop");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_status.empty)
    else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

/* rtl/scd_front.sv */
// Front part of the sequence command decoder: byte parser that spots command boundaries.
// Depends on scd_pkg.
`default_nettype none

module scd_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              byte_take,
  input  wire logic [7:0]        data_byte,
  output scd_pkg::cmd_push_t     push,
  output logic                   stopped
);
  import scd_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [7:0] pending_code_r, pending_code_nxt;
  logic [2:0] bytes_remaining_r, bytes_remaining_nxt;
  logic [2:0] kind;

  assign kind    = arg_kind(data_byte);
  assign stopped = (phase_r == PH_STOP);

  // Next phase and finished-command push
  always_comb begin
    phase_nxt           = phase_r;
    pending_code_nxt    = pending_code_r;
    bytes_remaining_nxt = bytes_remaining_r;
    push.valid          = 1'b0;
    push.code           = pending_code_r;
    if (byte_take) begin
      case (phase_r)
        PH_IDLE: begin
          pending_code_nxt = data_byte;
          push.code        = data_byte;
          if (data_byte == CODE_END || kind == KIND_BAD) begin
            push.valid = 1'b1;
            phase_nxt  = PH_STOP;
          end else if (data_byte < CODE_NOTE_LIMIT) begin
            phase_nxt = PH_VEL;
          end else if (kind == KIND_VAR) begin
            phase_nxt = PH_VARLEN;
          end else if (kind == 3'd0) begin
            push.valid = 1'b1;
          end else begin
            bytes_remaining_nxt = kind;
            phase_nxt           = PH_FIXED;
          end
        end
        PH_VEL: phase_nxt = PH_VARLEN;
        PH_VARLEN: begin
          // continuation bit set: more length bytes follow
          if (!data_byte[7]) begin
            push.valid = 1'b1;
            phase_nxt  = PH_IDLE;
          end
        end
        PH_FIXED: begin
          bytes_remaining_nxt = bytes_remaining_r - 3'd1;
          if (bytes_remaining_r <= 3'd1) begin
            bytes_remaining_nxt = 3'd0;
            push.valid          = 1'b1;
            phase_nxt           = PH_IDLE;
          end
        end
        PH_STOP: phase_nxt = PH_STOP;
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  // Hold parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r           <= PH_IDLE;
      pending_code_r    <= '0;
      bytes_remaining_r <= '0;
    end else begin
      phase_r           <= phase_nxt;
      pending_code_r    <= pending_code_nxt;
      bytes_remaining_r <= bytes_remaining_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/scd_queue.sv */
// Short queue of finished command codes between front and back.
// Depends on scd_pkg.
`default_nettype none

module scd_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire scd_pkg::cmd_push_t   push,
  input  wire logic                 pop,
  output logic [7:0]                head_code,
  output scd_pkg::queue_status_t    status
);
  import scd_pkg::*;

  logic [7:0]        mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign status.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign status.empty = (count_r == '0);
  assign head_code    = mem_r[rd_ptr_r];

  // Store entries
  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_ptr_r] <= push.code;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push.valid) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      case ({push.valid, pop})
        2'b10:   count_r <= count_r + QCNT_W'(1);
        2'b01:   count_r <= count_r - QCNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/scd_back.sv */
// Back part: takes finished commands from the queue and presents them on the result channel.
// Depends on scd_pkg.
`default_nettype none

module scd_back (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire scd_pkg::queue_status_t q_status,
  input  wire logic [7:0]             head_code,
  output logic                        pop,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [7:0]                  out_command_code
);
  import scd_pkg::*;

  logic       out_valid_r;
  logic [7:0] out_code_r;

  // Refill the output register when it is empty or being taken
  assign pop = !q_status.empty && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_code_r <= head_code;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_command_code = out_code_r;

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// Self-checking testbench for sequence_command_decoder: directed table, random tracks, then a track stop.
// Expected command codes come from a local decoder model; depends on scd_pkg and the RTL.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import scd_pkg::*;

  // Command codes with their own handling in the decoder model
  localparam logic [7:0] OP_WAIT      = 8'h80;
  localparam logic [7:0] OP_JUMP      = 8'h94;
  localparam logic [7:0] OP_CALL      = 8'h95;
  localparam logic [7:0] OP_RETURN    = 8'hFD;
  localparam logic [7:0] OP_NOTEWAIT  = 8'hC7;
  localparam logic [7:0] NOTE_LOWEST  = 8'h00;
  localparam logic [7:0] NOTE_HIGHEST = 8'h7F;

  localparam logic [31:0] JUMP_OFFSET  = 32'h1C;
  localparam logic [31:0] CALL_SIZE    = 32'd4;
  localparam int          VARLEN_MAX   = 4;
  localparam int          LIMIT_CYCLES = 400_000;
  localparam int          PRESSURE_AT  = 400;
  localparam int          PRESSURE_LEN = 300;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_t;

  typedef struct packed {
    logic [7:0] data;
    bit         typed;
    logic [7:0] code;
  } stim_row_t;

  logic        clk;
  logic        rst_n            = 1'b0;
  logic        cfg_valid        = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index        = '0;
  logic [31:0] cfg_data         = '0;
  logic        in_valid         = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte     = '0;
  logic        out_valid;
  logic        out_ready        = 1'b0;
  logic [7:0]  out_command_code;

  // Decoder model: configuration copy and parse state
  logic [31:0] seq_base_reg, track_start_reg;
  logic        notewait_reg;
  logic [31:0] fetch_addr, ret_addr, cmd_addr, delta_now;
  logic        notewait_mode, dur_overflow;
  logic [7:0]  cur_code, arg_byte;
  logic [2:0]  args_left, dur_bytes;
  logic [27:0] dur_acc;
  logic [23:0] word_a;
  logic [15:0] word_b;
  phase_t      parse_ph;

  logic [7:0]  expected_codes[$];
  int          error_count    = 0;
  int          cycle_count    = 0;
  int          bytes_accepted = 0;
  int          burst_left     = 0;

  // Directed track: extremes, call/return, jump, notewait, long duration field
  stim_row_t directed_rows [0:23] = '{
    '{OP_RETURN,    1'b1, OP_RETURN},     // return before any call
    '{NOTE_LOWEST,  1'b0, 8'h00},
    '{8'h7F,        1'b0, 8'h00},
    '{8'h00,        1'b1, NOTE_LOWEST},
    '{NOTE_HIGHEST, 1'b0, 8'h00},
    '{8'hFF,        1'b0, 8'h00},
    '{8'h80,        1'b0, 8'h00},         // five-byte duration: too long
    '{8'h80,        1'b0, 8'h00},
    '{8'h80,        1'b0, 8'h00},
    '{8'h80,        1'b0, 8'h00},
    '{8'h00,        1'b1, NOTE_HIGHEST},
    '{OP_NOTEWAIT,  1'b0, 8'h00},
    '{8'h00,        1'b0, 8'h00},
    '{OP_CALL,      1'b0, 8'h00},
    '{8'hFF,        1'b0, 8'h00},
    '{8'hFF,        1'b0, 8'h00},
    '{8'hFF,        1'b1, OP_CALL},
    '{OP_RETURN,    1'b1, OP_RETURN},
    '{OP_JUMP,      1'b0, 8'h00},
    '{8'h00,        1'b0, 8'h00},
    '{8'h00,        1'b0, 8'h00},
    '{8'h00,        1'b1, OP_JUMP},
    '{OP_WAIT,      1'b0, 8'h00},
    '{8'h7F,        1'b0, 8'h00}
  };

  sequence_command_decoder dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_command_code (out_command_code)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Argument bytes after a code: 0..5 fixed, KIND_VAR or KIND_BAD
  function automatic logic [2:0] args_after(input logic [7:0] c);
    if (c < CODE_NOTE_LIMIT) return 3'd1;
    if (c == 8'h80 || c == 8'h81) return KIND_VAR;
    if (c == 8'h93) return 3'd4;
    if (c == OP_JUMP || c == OP_CALL) return 3'd3;
    if (c == 8'hA0) return 3'd5;
    if (c == 8'hA1) return 3'd2;
    if (c == 8'hA2 || c == 8'hFC || c == OP_RETURN) return 3'd0;
    if (c >= 8'hB0 && c <= 8'hBD && c != 8'hB7) return 3'd3;
    if (c >= 8'hC0 && c <= 8'hD6) return 3'd1;
    if (c == 8'hE0 || c == 8'hE1 || c == 8'hE3 || c == 8'hFE) return 3'd2;
    return KIND_BAD;
  endfunction

  function automatic bit stops_track(input logic [7:0] c);
    return (c == CODE_END) || (args_after(c) == KIND_BAD);
  endfunction

  // Close the pending command and apply its side effects
  task automatic retire_command(output bit has_code, output logic [7:0] code);
    if (cur_code < CODE_NOTE_LIMIT) begin
      if (notewait_mode) delta_now = {4'd0, dur_acc};
    end else if (cur_code == OP_WAIT) begin
      delta_now = {4'd0, dur_acc};
    end else if (cur_code == OP_JUMP) begin
      fetch_addr = {8'd0, word_a} + seq_base_reg + JUMP_OFFSET;
    end else if (cur_code == OP_CALL) begin
      ret_addr   = cmd_addr + CALL_SIZE;
      fetch_addr = {8'd0, word_a} + seq_base_reg + JUMP_OFFSET;
    end else if (cur_code == OP_RETURN) begin
      fetch_addr = ret_addr;
    end else if (cur_code == OP_NOTEWAIT) begin
      notewait_mode = (arg_byte != 8'd0);
    end
    parse_ph = (cur_code == CODE_END) ? PH_STOP : PH_IDLE;
    has_code = 1'b1;
    code     = cur_code;
  endtask

  task automatic open_duration();
    dur_acc      = '0;
    dur_bytes    = '0;
    dur_overflow = 1'b0;
    parse_ph     = PH_VARLEN;
  endtask

  // Advance the model by one accepted byte
  task automatic decode_byte(input logic [7:0] b, output bit has_code, output logic [7:0] code);
    logic [2:0] k;
    logic [2:0] pos;
    has_code = 1'b0;
    code     = '0;
    if (parse_ph == PH_STOP) return;
    fetch_addr = fetch_addr + 32'd1;
    case (parse_ph)
      PH_IDLE: begin
        cmd_addr  = fetch_addr - 32'd1;
        cur_code  = b;
        word_a    = '0;
        word_b    = '0;
        arg_byte  = '0;
        delta_now = '0;
        k = args_after(b);
        if (b == CODE_END) begin
          retire_command(has_code, code);
        end else if (k == KIND_BAD) begin
          parse_ph = PH_STOP;
          has_code = 1'b1;
          code     = b;
        end else if (b < CODE_NOTE_LIMIT) begin
          parse_ph = PH_VEL;
        end else if (k == KIND_VAR) begin
          open_duration();
        end else if (k == 3'd0) begin
          retire_command(has_code, code);
        end else begin
          args_left = k;
          parse_ph  = PH_FIXED;
        end
      end
      PH_VEL: begin
        arg_byte = b;
        open_duration();
      end
      PH_VARLEN: begin
        dur_acc = {dur_acc[20:0], b[6:0]};
        if (dur_bytes < 3'd7) dur_bytes = dur_bytes + 3'd1;
        if (dur_bytes > VARLEN_MAX) dur_overflow = 1'b1;
        if (!b[7]) retire_command(has_code, code);
      end
      default: begin
        k = args_after(cur_code);
        if (k > 3'd5) k = 3'd5;
        pos = k - args_left;
        if (pos == 3'd0) arg_byte = b;
        if (pos < 3'd3) word_a = word_a | (24'(b) << (8 * pos));
        else if (pos < 3'd5) word_b = word_b | (16'(b) << (8 * (pos - 3'd3)));
        if (args_left > 3'd0) args_left = args_left - 3'd1;
        if (args_left == 3'd0) retire_command(has_code, code);
      end
    endcase
  endtask

  // Offer one byte in bursts with random gaps; predict on acceptance
  task automatic feed_byte(input logic [7:0] b, input bit typed, input logic [7:0] typed_code);
    int         gap;
    bit         has_code;
    logic [7:0] code;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 160) : $urandom_range(1, 16);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    bytes_accepted++;
    decode_byte(b, has_code, code);
    if (typed) expected_codes = {expected_codes, typed_code};
    else if (has_code) expected_codes = {expected_codes, code};
  endtask

  task automatic feed_random(input logic [7:0] b);
    feed_byte(b, 1'b0, 8'h00);
  endtask

  // Duration field: mostly short, sometimes past the limit and the count ceiling
  task automatic feed_duration();
    int n;
    n = ($urandom_range(0, 9) < 7) ? $urandom_range(1, VARLEN_MAX) : $urandom_range(5, 9);
    for (int i = 1; i < n; i++) feed_random({1'b1, 7'($urandom_range(0, 127))});
    feed_random({1'b0, 7'($urandom_range(0, 127))});
  endtask

  // Finish whatever command is open so the parser sits at a command boundary
  task automatic close_command();
    while (parse_ph != PH_IDLE && parse_ph != PH_STOP) begin
      if (parse_ph == PH_VARLEN) feed_random(8'($urandom_range(0, 127)));
      else feed_random(8'($urandom));
    end
  endtask

  // Random well-formed commands with some stray code bytes mixed in
  task automatic random_track(input int byte_target);
    int         start_count;
    int         pick;
    logic [7:0] c;
    logic [2:0] k;
    start_count = bytes_accepted;
    while (bytes_accepted - start_count < byte_target) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        do c = 8'($urandom); while (stops_track(c));
        feed_random(c);
        close_command();
      end else if (pick < 45) begin
        feed_random(8'($urandom_range(0, 127)));
        feed_random(8'($urandom));
        feed_duration();
      end else begin
        do c = 8'($urandom_range(128, 255)); while (stops_track(c));
        feed_random(c);
        k = args_after(c);
        if (k == KIND_VAR) feed_duration();
        else for (int i = 0; i < k; i++) feed_random(8'($urandom));
      end
    end
    close_command();
  endtask

  // Drop valid, wait for all results, then allow for in-flight work
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_codes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write all three registers back to back while the block is idle
  task automatic load_settings(input logic [31:0] base, input logic [31:0] start, input logic nw);
    logic [1:0]  idx_list [3];
    logic [31:0] val_list [3];
    idx_list = '{CFG_SEQUENCE_BASE, CFG_TRACK_START, CFG_NOTEWAIT_DEFAULT};
    val_list = '{base, start, {31'd0, nw}};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx_list[i];
      cfg_data  <= val_list[i];
      do @(posedge clk); while (!cfg_ready);
      case (idx_list[i])
        CFG_SEQUENCE_BASE: seq_base_reg = val_list[i];
        CFG_TRACK_START: begin
          track_start_reg = val_list[i];
          fetch_addr      = val_list[i];
        end
        CFG_NOTEWAIT_DEFAULT: begin
          notewait_reg  = val_list[i][0];
          notewait_mode = val_list[i][0];
        end
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // Result checker: compare each transaction with the oldest expectation
  always @(posedge clk) begin
    logic [7:0] want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_codes.size() == 0) begin
        $error("command_code: unexpected result, actual %02h", out_command_code);
        error_count++;
      end else begin
        want = expected_codes.pop_front();
        if (out_command_code !== want) begin
          $error("command_code: expected %02h, actual %02h", want, out_command_code);
          error_count++;
        end
      end
    end
  end

  // Receiver: changing stall patterns, plus one long hold-off to back up the block
  initial begin
    rx_mode_t mode;
    int       mode_left;
    int       hold_left;
    bit       pressure_done;
    mode          = RX_OPEN;
    mode_left     = 0;
    hold_left     = 0;
    pressure_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!pressure_done && bytes_accepted >= PRESSURE_AT) begin
        hold_left     = PRESSURE_LEN;
        pressure_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        case (mode)
          RX_OPEN:   out_ready <= 1'b1;
          RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
          default:   out_ready <= ~out_ready;
        endcase
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    logic [7:0] stop_code;
    // Model state after reset
    seq_base_reg    = '0;
    track_start_reg = '0;
    notewait_reg    = 1'b1;
    fetch_addr      = '0;
    ret_addr        = '0;
    notewait_mode   = 1'b1;
    cur_code        = '0;
    cmd_addr        = '0;
    args_left       = '0;
    dur_acc         = '0;
    dur_bytes       = '0;
    dur_overflow    = 1'b0;
    word_a          = '0;
    word_b          = '0;
    arg_byte        = '0;
    delta_now       = '0;
    parse_ph        = PH_IDLE;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Extreme settings: addresses wrap, notes do not add delta time
    load_settings(32'hFFFF_FFFF, 32'hFFFF_FFF0, 1'b0);
    foreach (directed_rows[i])
      feed_byte(directed_rows[i].data, directed_rows[i].typed, directed_rows[i].code);
    drain_results();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: load_settings($urandom, $urandom, 1'($urandom_range(0, 1)));
        1: load_settings(32'h0000_0000, 32'h0000_0000, 1'b1);
        2: load_settings($urandom, $urandom, 1'($urandom_range(0, 1)));
        default: load_settings(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
      endcase
      random_track(280);
      drain_results();
    end

    // Stop the track with the end code or an unknown code; later bytes are ignored
    if ($urandom_range(0, 1) == 0) stop_code = CODE_END;
    else do stop_code = 8'($urandom_range(128, 255)); while (args_after(stop_code) != KIND_BAD);
    feed_random(stop_code);
    repeat (6) feed_random(8'($urandom));
    in_valid <= 1'b0;

    while (expected_codes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
